>>> rtl/ecal_pkg.sv
package ecal_pkg;

  localparam logic [31:0] SecsPerDay   = 32'd86400;
  localparam logic [31:0] SecsPerHour  = 32'd3600;
  localparam logic [31:0] SecsPerMin   = 32'd60;
  localparam logic [31:0] QuadDays     = 32'd1461;
  localparam logic [31:0] YearDays     = 32'd365;
  localparam logic [31:0] LeapYearDays = 32'd366;
  // first day number at or after 2100-03-01; 2100 has no Feb 29
  localparam logic [31:0] Feb29Skip    = 32'd47541;

  localparam int DayBits  = 16;
  localparam int HourBits = 5;
  localparam int MinBits  = 6;
  localparam int QuadBits = 6;

  localparam logic [3:0] YearLastStep  = 4'd2;
  localparam logic [3:0] MonthLastStep = 4'd10;
  localparam logic [1:0] LeapYearIdx   = 2'd2;

  localparam logic [7:0] BaseYearMod = 8'd70;
  localparam logic [7:0] Century     = 8'd100;
  localparam logic [7:0] TwoCentury  = 8'd200;

  localparam logic [4:0] DaysInMonth [16] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
    5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0,  5'd0
  };

  typedef struct packed {
    logic        ge;
    logic [31:0] diff;
  } ecal_alu_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ecal_stat_t;

  typedef struct packed {
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } cal_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = DaysInMonth[m];
    if (m == 4'd1 && leap) begin
      len = len + 5'd1;
    end
    return len;
  endfunction

  // v below 100: tens digit by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = 15'(v) * 15'd205;
    t = p[14:11];
    u = v - 7'(t) * 7'd10;
    return {t, u[3:0]};
  endfunction

endpackage

>>> rtl/ecal_epoch_if.sv
interface ecal_epoch_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

>>> rtl/ecal_cal_if.sv
interface ecal_cal_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_bcd;
  logic [4:0] month_bcd;
  logic [5:0] day_bcd;
  logic [5:0] hour_bcd;
  logic [6:0] minute_bcd;
  logic [6:0] second_bcd;

  modport source (output valid, output year_bcd, output month_bcd, output day_bcd,
                  output hour_bcd, output minute_bcd, output second_bcd, input ready);
  modport sink (input valid, input year_bcd, input month_bcd, input day_bcd,
                input hour_bcd, input minute_bcd, input second_bcd, output ready);
endinterface

>>> rtl/ecal_alu.sv
module ecal_alu (
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  output ecal_pkg::ecal_alu_t  res
);
  import ecal_pkg::*;

  logic [32:0] wide;

  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~wide[32];
  assign res.diff = wide[31:0];

endmodule

>>> rtl/ecal_core.sv
module ecal_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          secs,
  input  logic                 take,
  output ecal_pkg::ecal_stat_t stat,
  output ecal_pkg::cal_t       result
);
  import ecal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DAY, S_HOUR, S_MIN, S_ADJ, S_QUAD, S_YEAR, S_MONTH, S_DONE
  } state_t;

  state_t      state;
  logic [31:0] acc;
  logic [31:0] opnd;
  logic [31:0] acc_sub;
  ecal_alu_t   alu;
  logic [3:0]  step;
  logic [15:0] days;
  logic [4:0]  hh;
  logic [5:0]  mm;
  logic [5:0]  ss;
  logic [5:0]  quad;
  logic [1:0]  yk;
  logic [3:0]  mon;
  logic        walking;

  logic [7:0]  yoff;
  logic [7:0]  yv;
  logic [6:0]  ymod;
  logic [7:0]  b_year;
  logic [7:0]  b_mon;
  logic [7:0]  b_day;
  logic [7:0]  b_hour;
  logic [7:0]  b_min;
  logic [7:0]  b_sec;

  ecal_alu u_alu (
    .a   (acc),
    .b   (opnd),
    .res (alu)
  );

  assign acc_sub = alu.ge ? alu.diff : acc;

  always_comb begin
    unique case (state)
      S_DAY:   opnd = SecsPerDay << step;
      S_HOUR:  opnd = SecsPerHour << step;
      S_MIN:   opnd = SecsPerMin << step;
      S_ADJ:   opnd = Feb29Skip;
      S_QUAD:  opnd = QuadDays << step;
      S_YEAR:  opnd = (step == YearLastStep) ? LeapYearDays : YearDays;
      S_MONTH: opnd = 32'(month_len(step, yk == LeapYearIdx));
      default: opnd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      walking <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            acc   <= secs;
            step  <= 4'(DayBits - 1);
            state <= S_DAY;
          end
        end
        S_DAY: begin
          acc  <= acc_sub;
          days <= {days[14:0], alu.ge};
          if (step == 4'd0) begin
            step  <= 4'(HourBits - 1);
            state <= S_HOUR;
          end else begin
            step <= step - 4'd1;
          end
        end
        S_HOUR: begin
          acc <= acc_sub;
          hh  <= {hh[3:0], alu.ge};
          if (step == 4'd0) begin
            step  <= 4'(MinBits - 1);
            state <= S_MIN;
          end else begin
            step <= step - 4'd1;
          end
        end
        S_MIN: begin
          mm <= {mm[4:0], alu.ge};
          if (step == 4'd0) begin
            ss    <= acc_sub[5:0];
            acc   <= {16'd0, days};
            state <= S_ADJ;
          end else begin
            acc  <= acc_sub;
            step <= step - 4'd1;
          end
        end
        S_ADJ: begin
          // skip the nonexistent Feb 29 2100 so every fourth year is leap
          if (alu.ge) begin
            acc <= acc + 32'd1;
          end
          step  <= 4'(QuadBits - 1);
          state <= S_QUAD;
        end
        S_QUAD: begin
          acc  <= acc_sub;
          quad <= {quad[4:0], alu.ge};
          if (step == 4'd0) begin
            yk    <= 2'd0;
            state <= S_YEAR;
          end else begin
            step <= step - 4'd1;
          end
        end
        S_YEAR: begin
          acc <= acc_sub;
          if (alu.ge) begin
            yk <= yk + 2'd1;
          end
          if (step == YearLastStep) begin
            step    <= 4'd0;
            mon     <= 4'd0;
            walking <= 1'b1;
            state   <= S_MONTH;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_MONTH: begin
          if (walking && alu.ge) begin
            acc <= alu.diff;
            mon <= mon + 4'd1;
          end else begin
            walking <= 1'b0;
          end
          if (step == MonthLastStep) begin
            state <= S_DONE;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    yoff = {quad, 2'b00} + 8'(yk);
    yv   = BaseYearMod + yoff;
    if (yv >= TwoCentury) begin
      ymod = 7'(yv - TwoCentury);
    end else if (yv >= Century) begin
      ymod = 7'(yv - Century);
    end else begin
      ymod = yv[6:0];
    end
  end

  assign b_year = to_bcd(ymod);
  assign b_mon  = to_bcd(7'(mon) + 7'd1);
  assign b_day  = to_bcd(acc[6:0] + 7'd1);
  assign b_hour = to_bcd(7'(hh));
  assign b_min  = to_bcd(7'(mm));
  assign b_sec  = to_bcd(7'(ss));

  assign result.year_bcd   = b_year;
  assign result.month_bcd  = b_mon[4:0];
  assign result.day_bcd    = b_day[5:0];
  assign result.hour_bcd   = b_hour[5:0];
  assign result.minute_bcd = b_min[6:0];
  assign result.second_bcd = b_sec[6:0];

  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE);

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE) else $error("start while busy");
  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    state == S_HOUR |-> acc < SecsPerDay) else $error("time of day out of range");
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MIN |-> hh < 5'd24) else $error("hour out of range");
  a_quad_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_YEAR |-> acc < QuadDays) else $error("quad remainder out of range");
  a_day_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> acc < 32'd31) else $error("day of month out of range");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (take && state == S_DONE) |=> state == S_IDLE) else $error("no return to idle");

endmodule

>>> rtl/epoch_seconds_to_bcd_calendar.sv
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00 into the
// Gregorian date and time as packed BCD (year mod 100, month, day, hour, minute,
// second), valid through 2106-02-07 06:28:15. A single 32-bit compare-subtract
// unit runs every cycle under a sequencer through the day count, hours and minutes,
// the 2100 leap correction, the four-year count, the year within it and the month
// walk, after the item is accepted; the result is then handed to the output register
// once that register is empty or being read. The output register lets the next item
// start while a result waits to be taken; the core takes no new item until it has
// handed its result to that register.
module epoch_seconds_to_bcd_calendar (
  input  logic          clk,
  input  logic          rst,
  ecal_epoch_if.sink    epoch,
  ecal_cal_if.source    calendar
);
  import ecal_pkg::*;

  ecal_stat_t stat;
  cal_t       result;
  cal_t       held;
  logic       held_valid;
  logic       start;
  logic       take;

  assign epoch.ready = ~stat.busy;
  assign start       = epoch.valid & ~stat.busy;
  assign take        = stat.done & (~held_valid | calendar.ready);

  ecal_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .secs   (epoch.epoch_seconds),
    .take   (take),
    .stat   (stat),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (calendar.ready) begin
      held_valid <= 1'b0;
    end
    if (take) begin
      held <= result;
    end
  end

  assign calendar.valid      = held_valid;
  assign calendar.year_bcd   = held.year_bcd;
  assign calendar.month_bcd  = held.month_bcd;
  assign calendar.day_bcd    = held.day_bcd;
  assign calendar.hour_bcd   = held.hour_bcd;
  assign calendar.minute_bcd = held.minute_bcd;
  assign calendar.second_bcd = held.second_bcd;

endmodule

>>> test/epoch_seconds_to_bcd_calendar_tb.sv
`timescale 1ns / 1ps

module epoch_seconds_to_bcd_calendar_tb;
  import ecal_pkg::*;

  localparam int unsigned DaySecs   = 86400;
  localparam int unsigned HourSecs  = 3600;
  localparam int unsigned MinSecs   = 60;
  localparam int unsigned EpochYear = 1970;
  localparam int unsigned LastDay   = 49710;
  localparam int          RandomItems = 850;
  localparam int          LongHold    = 500;
  localparam int          SettleCycles = 60;

  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef enum logic [1:0] {
    RecvSteady,
    RecvChoppy,
    RecvSparse
  } recv_mode_t;

  logic clk;
  logic rst;

  ecal_epoch_if epoch_ch ();
  ecal_cal_if   cal_ch ();

  cal_t       expected_cal [$];
  int         error_count;
  int         burst_left;
  bit         hold_request;
  int         hold_left;
  int         mode_left;
  recv_mode_t recv_mode;

  epoch_seconds_to_bcd_calendar i_dut (
    .clk      (clk),
    .rst      (rst),
    .epoch    (epoch_ch),
    .calendar (cal_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned leap_days(input int unsigned y);
    if (y % 400 == 0) begin
      return 1;
    end
    if (y % 100 == 0) begin
      return 0;
    end
    return (y % 4 == 0) ? 1 : 0;
  endfunction

  function automatic logic [7:0] two_digit_bcd(input int unsigned v);
    return {4'((v / 10) % 10), 4'(v % 10)};
  endfunction

  function automatic cal_t calendar_of(input logic [31:0] secs);
    int unsigned days;
    int unsigned tod;
    int unsigned yr;
    int unsigned mon;
    int unsigned span;
    logic [7:0]  b;
    cal_t        c;
    days = secs / DaySecs;
    tod  = secs % DaySecs;
    yr   = EpochYear;
    span = 365 + leap_days(yr);
    while (days >= span) begin
      days = days - span;
      yr   = yr + 1;
      span = 365 + leap_days(yr);
    end
    mon = 0;
    while (mon < 11) begin
      span = MonthDays[mon] + ((mon == 1) ? leap_days(yr) : 0);
      if (days < span) begin
        break;
      end
      days = days - span;
      mon  = mon + 1;
    end
    c.year_bcd   = two_digit_bcd(yr % 100);
    b            = two_digit_bcd(mon + 1);
    c.month_bcd  = b[4:0];
    b            = two_digit_bcd(days + 1);
    c.day_bcd    = b[5:0];
    b            = two_digit_bcd(tod / HourSecs);
    c.hour_bcd   = b[5:0];
    b            = two_digit_bcd((tod % HourSecs) / MinSecs);
    c.minute_bcd = b[6:0];
    b            = two_digit_bcd(tod % MinSecs);
    c.second_bcd = b[6:0];
    return c;
  endfunction

  // receiver: random ready with changing density, plus long hold on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LongHold;
      hold_request = 1'b0;
    end
    if (mode_left == 0) begin
      recv_mode = recv_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left = mode_left - 1;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      cal_ch.ready <= 1'b0;
    end else begin
      case (recv_mode)
        RecvSteady: begin
          cal_ch.ready <= 1'b1;
        end
        RecvChoppy: begin
          cal_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          cal_ch.ready <= ($urandom_range(0, 9) != 0);
        end
      endcase
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    cal_t want;
    if (!rst && cal_ch.valid && cal_ch.ready) begin
      if (expected_cal.size() == 0) begin
        $error("calendar item with no pending epoch item");
        error_count++;
      end else begin
        want = expected_cal.pop_front();
        check_field("year_bcd", want.year_bcd, cal_ch.year_bcd);
        check_field("month_bcd", want.month_bcd, cal_ch.month_bcd);
        check_field("day_bcd", want.day_bcd, cal_ch.day_bcd);
        check_field("hour_bcd", want.hour_bcd, cal_ch.hour_bcd);
        check_field("minute_bcd", want.minute_bcd, cal_ch.minute_bcd);
        check_field("second_bcd", want.second_bcd, cal_ch.second_bcd);
      end
    end
  end

  task automatic send_epoch(input logic [31:0] secs);
    epoch_ch.valid         <= 1'b1;
    epoch_ch.epoch_seconds <= secs;
    do @(posedge clk); while (!(epoch_ch.valid && epoch_ch.ready));
    expected_cal.push_back(calendar_of(secs));
  endtask

  task automatic send_in_bursts(input logic [31:0] secs);
    if (burst_left == 0) begin
      epoch_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    send_epoch(secs);
    burst_left--;
  endtask

  task automatic idle_sender();
    epoch_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_done();
    while (expected_cal.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] stamps [$];
    stamps = '{
      32'd0, 32'hFFFF_FFFF, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
      32'd86399, 32'd86400, 32'd2592000, 32'd2678400, 32'd68169600,
      32'd94607999, 32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
      32'd3981312000, 32'd4102444800, 32'd4107542399, 32'd4107542400,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
    };
    foreach (stamps[i]) begin
      send_in_bursts(stamps[i]);
    end
    idle_sender();
  endtask

  task automatic test_random(input int count);
    int unsigned day;
    int unsigned tod;
    longint      stamp;
    repeat (count) begin
      if ($urandom_range(0, 9) < 4) begin
        stamp = $urandom;
      end else begin
        day = $urandom_range(0, LastDay);
        case ($urandom_range(0, 2))
          0: tod = $urandom_range(0, 2);
          1: tod = DaySecs - 1 - $urandom_range(0, 2);
          default: tod = $urandom_range(0, DaySecs - 1);
        endcase
        stamp = longint'(day) * DaySecs + tod;
        if (stamp > 64'hFFFF_FFFF) begin
          stamp = $urandom;
        end
      end
      send_in_bursts(stamp[31:0]);
    end
    idle_sender();
  endtask

  task automatic test_backpressure();
    wait_results_done();
    hold_request = 1'b1;
    repeat (10) begin
      send_epoch($urandom);
    end
    idle_sender();
    wait_results_done();
    repeat (6) begin
      send_epoch($urandom);
    end
    idle_sender();
  endtask

  initial begin
    rst                    = 1'b1;
    epoch_ch.valid         = 1'b0;
    epoch_ch.epoch_seconds = '0;
    cal_ch.ready           = 1'b0;
    error_count            = 0;
    burst_left             = 0;
    hold_request           = 1'b0;
    hold_left              = 0;
    mode_left              = 0;
    recv_mode              = RecvSteady;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(RandomItems);

    wait_results_done();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0 && expected_cal.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (expected_cal.size() != 0) begin
        $error("%0d calendar items never arrived", expected_cal.size());
      end
      $display("Verification failed");
    end
    $finish;
  end

endmodule
